// ===== sv/emst_pkg.sv =====
// Shared constants for the spanning tree block: field widths, kinds, register map.
`timescale 1ns / 1ps
package emst_pkg;
   localparam int KIND_BITS  = 2;
   localparam int END_BITS   = 11;
   localparam int CFG_BITS   = 11;
   localparam int TOTAL_BITS = 47;
   localparam int DATA_BITS  = 32;
   localparam int ADDR_BITS  = 3;

   localparam logic [KIND_BITS-1:0] KIND_LOAD   = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_LINK   = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_FINISH = 2'd2;

   localparam logic [CFG_BITS-1:0]   POINT_COUNT_RESET = 11'd1;
   localparam logic                  REG_POINT_COUNT   = 1'b0;
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX         = '1;
endpackage

// ===== sv/emst_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, index carried along.
`timescale 1ns / 1ps
module emst_sqrt #(
   parameter int IDX_BITS = 10,
   parameter int RAD_BITS = 73
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [IDX_BITS-1:0]            in_idx,
   input  logic [RAD_BITS-1:0]            in_rad,
   output logic                           out_valid,
   output logic [IDX_BITS-1:0]            out_idx,
   output logic [(RAD_BITS+1)/2-1:0]      out_root,
   output logic                           busy
);
   localparam int RW = (RAD_BITS + 1) / 2;
   localparam int PW = 2 * RW;

   logic              v_ff   [RW];
   logic [IDX_BITS-1:0] idx_ff [RW];
   logic [RW:0]       rem_ff [RW];
   logic [RW-1:0]     q_ff   [RW];
   logic [PW-1:0]     rad_ff [RW];

   genvar s;
   for (s = 0; s < RW; s++) begin : g_stage
      logic                pv;
      logic [IDX_BITS-1:0] pidx;
      logic [RW:0]         prem;
      logic [RW-1:0]       pq;
      logic [PW-1:0]       prad;
      logic [RW+2:0]       cur;
      logic [RW+2:0]       sub;
      logic [RW+2:0]       diff;

      if (s == 0) begin : g_first
         assign pv   = in_valid;
         assign pidx = in_idx;
         assign prem = '0;
         assign pq   = '0;
         assign prad = PW'(in_rad);
      end else begin : g_next
         assign pv   = v_ff[s-1];
         assign pidx = idx_ff[s-1];
         assign prem = rem_ff[s-1];
         assign pq   = q_ff[s-1];
         assign prad = rad_ff[s-1];
      end

      assign cur  = {prem, prad[PW-1:PW-2]};
      assign sub  = {1'b0, pq, 2'b01};
      assign diff = cur - sub;

      always_ff @(posedge clock) begin
         idx_ff[s] <= pidx;
         rad_ff[s] <= {prad[PW-3:0], 2'b00};
         if (cur >= sub) begin
            rem_ff[s] <= diff[RW:0];
            q_ff[s]   <= {pq[RW-2:0], 1'b1};
         end else begin
            rem_ff[s] <= cur[RW:0];
            q_ff[s]   <= {pq[RW-2:0], 1'b0};
         end
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else begin
            v_ff[s] <= pv;
         end
      end
   end

   always_comb begin
      busy = 1'b0;
      for (int k = 0; k < RW; k++) begin
         busy = busy | v_ff[k];
      end
   end

   assign out_valid = v_ff[RW-1];
   assign out_idx   = idx_ff[RW-1];
   assign out_root  = q_ff[RW-1];
endmodule

// ===== sv/emst_dist.sv =====
// Point memory and distance pipeline: abs difference, squares, shifted sum, square root.
`timescale 1ns / 1ps
module emst_dist #(
   parameter int MAX_POINTS = 1024,
   parameter int COORD_BITS = 20,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  wr_en,
   input  logic [$clog2(MAX_POINTS)-1:0]         wr_idx,
   input  logic [COORD_BITS-1:0]                 wr_x,
   input  logic [COORD_BITS-1:0]                 wr_y,
   input  logic                                  rd_en,
   input  logic                                  rd_pivot,
   input  logic [$clog2(MAX_POINTS)-1:0]         rd_idx,
   output logic                                  out_valid,
   output logic [$clog2(MAX_POINTS)-1:0]         out_idx,
   output logic [COORD_BITS+FRAC_BITS:0]         out_len,
   output logic                                  busy
);
   localparam int IW = $clog2(MAX_POINTS);
   localparam int CB = COORD_BITS;
   localparam int TW = 2 * CB + 1 + 2 * FRAC_BITS;

   logic [2*CB-1:0] pt_mem [MAX_POINTS];
   logic [2*CB-1:0] pt_q;
   logic            rd_v_ff, rd_piv_ff;
   logic [IW-1:0]   rd_idx_ff;
   logic [CB-1:0]   px_ff, py_ff;
   logic [CB-1:0]   qx, qy;

   logic            a_v_ff;
   logic [IW-1:0]   a_idx_ff;
   logic [CB-1:0]   dx_ff, dy_ff;
   logic            b_v_ff;
   logic [IW-1:0]   b_idx_ff;
   logic [2*CB-1:0] sx_ff, sy_ff;
   logic            c_v_ff;
   logic [IW-1:0]   c_idx_ff;
   logic [TW-1:0]   t_ff;
   logic            sq_busy;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pt_mem[wr_idx] <= {wr_x, wr_y};
      end
      if (rd_en) begin
         pt_q <= pt_mem[rd_idx];
      end
   end

   assign qx = pt_q[2*CB-1:CB];
   assign qy = pt_q[CB-1:0];

   always_ff @(posedge clock) begin
      rd_piv_ff <= rd_pivot;
      rd_idx_ff <= rd_idx;
      if (rd_v_ff && rd_piv_ff) begin
         px_ff <= qx;
         py_ff <= qy;
      end
      a_idx_ff <= rd_idx_ff;
      dx_ff    <= (px_ff > qx) ? px_ff - qx : qx - px_ff;
      dy_ff    <= (py_ff > qy) ? py_ff - qy : qy - py_ff;
      b_idx_ff <= a_idx_ff;
      sx_ff    <= dx_ff * dx_ff;
      sy_ff    <= dy_ff * dy_ff;
      c_idx_ff <= b_idx_ff;
      t_ff     <= TW'(({1'b0, sx_ff} + {1'b0, sy_ff})) << (2 * FRAC_BITS);
      if (reset) begin
         rd_v_ff <= 1'b0;
         a_v_ff  <= 1'b0;
         b_v_ff  <= 1'b0;
         c_v_ff  <= 1'b0;
      end else begin
         rd_v_ff <= rd_en;
         a_v_ff  <= rd_v_ff && !rd_piv_ff;
         b_v_ff  <= a_v_ff;
         c_v_ff  <= b_v_ff;
      end
   end

   emst_sqrt #(
      .IDX_BITS(IW),
      .RAD_BITS(TW)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_valid (c_v_ff),
      .in_idx   (c_idx_ff),
      .in_rad   (t_ff),
      .out_valid(out_valid),
      .out_idx  (out_idx),
      .out_root (out_len),
      .busy     (sq_busy)
   );

   assign busy = rd_v_ff | a_v_ff | b_v_ff | c_v_ff | sq_busy;
endmodule

// ===== sv/euclidean_mst_with_fixed_links.sv =====
// Top level: register port, node memory, union-find and Prim sequencer.
//
//  channel | dir | handshake         | words
//  req     | in  | req_valid/ready   | kind, coord_x, coord_y, end_a, end_b
//  rsp     | out | rsp_valid/ready   | total_length (finish only)
//  csr     | in  | psel/penable, APB | point_count at byte address 0
//
// A load is written in the idle state. A link walks the parent chain of each end to its root.
// A finish walks each point to its root, then scans the labels once, runs every point that
// joins the tree through the distance pipeline, and repeats selection rounds (scan, absorb
// pass, parent write); the node memory port sets the pace.
// Reset is synchronous; no clearing pass. A finished word waits in the output register
// while new words are taken; a second finish holds until it has been taken.
`timescale 1ns / 1ps
module euclidean_mst_with_fixed_links
   import emst_pkg::*;
#(
   parameter int MAX_POINTS = 1024,
   parameter int COORD_BITS = 20,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [KIND_BITS-1:0]  req_kind,
   input  logic [COORD_BITS-1:0] req_coord_x,
   input  logic [COORD_BITS-1:0] req_coord_y,
   input  logic [END_BITS-1:0]   req_end_a,
   input  logic [END_BITS-1:0]   req_end_b,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [TOTAL_BITS-1:0] rsp_total_length,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_BITS-1:0]  paddr,
   input  logic [DATA_BITS-1:0]  pwdata,
   output logic [DATA_BITS-1:0]  prdata,
   output logic                  pready
);
   localparam int IW = $clog2(MAX_POINTS);
   localparam int LW = $clog2(MAX_POINTS + 1);
   localparam int RW = COORD_BITS + FRAC_BITS + 1;
   localparam int NW = (LW > CFG_BITS) ? LW : CFG_BITS;
   localparam int SW = ((RW > TOTAL_BITS) ? RW : TOTAL_BITS) + 1;
   localparam int WW = 2 * IW + RW;

   typedef enum logic [4:0] {
      S_IDLE, S_FND_RD, S_FND_WT, S_LNK_B, S_LNK_C, S_LNK_W,
      S_INI_GO, S_INI_WR, S_RL0_RD, S_RL0_CK, S_RL0_NX,
      S_RLX_PIV, S_RLX_RUN, S_RLX_DRN,
      S_SEL_RD, S_SEL_CK, S_SEL_DN,
      S_ABS_RD, S_ABS_CK, S_ABS_NX, S_PAR_RD, S_PAR_WR, S_EMIT
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [LW-1:0]         loaded_ff, loaded_in;
   logic [CFG_BITS-1:0]   pc_ff, pc_in;
   logic [IW-1:0]         fr_ff, fr_in, save_par_ff, save_par_in, ra_ff, ra_in;
   logic [IW-1:0]         endb_ff, endb_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [IW-1:0]         i_ff, i_in, j_ff, j_in, k_ff, k_in, rb_ff, rb_in;
   logic [IW-1:0]         best_lab_ff, best_lab_in;
   logic [RW-1:0]         best_key_ff, best_key_in;
   logic                  first_ff, first_in, found_ff, found_in;
   logic [TOTAL_BITS-1:0] tot_ff, tot_in, rsp_data_ff, rsp_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  tail_v_ff, tail_v_in;
   logic [IW-1:0]         tail_idx_ff, tail_idx_in;
   logic [RW-1:0]         tail_len_ff, tail_len_in;

   logic [WW-1:0] node_mem [MAX_POINTS];
   logic [WW-1:0] nd_q, nd_wd;
   logic          nd_re, nd_we;
   logic [IW-1:0] nd_ra, nd_wa;
   logic [IW-1:0] nd_q_par, nd_q_lab;
   logic [RW-1:0] nd_q_key;

   logic          pt_we, d_re, d_piv, d_ov, d_busy;
   logic [IW-1:0] d_ridx, d_oidx;
   logic [RW-1:0] d_olen;

   logic [NW-1:0] n_w;
   logic [LW-1:0] n_cnt;
   logic [IW-1:0] last_idx;
   logic          load_ok, link_ok, cfg_wr;
   logic [SW-1:0] sum_w;

   always_ff @(posedge clock) begin
      if (nd_we) begin
         node_mem[nd_wa] <= nd_wd;
      end
      if (nd_re) begin
         nd_q <= node_mem[nd_ra];
      end
   end

   assign nd_q_par = nd_q[WW-1 -: IW];
   assign nd_q_lab = nd_q[RW+IW-1 -: IW];
   assign nd_q_key = nd_q[RW-1:0];

   emst_dist #(
      .MAX_POINTS(MAX_POINTS),
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (pt_we),
      .wr_idx   (IW'(loaded_ff)),
      .wr_x     (req_coord_x),
      .wr_y     (req_coord_y),
      .rd_en    (d_re),
      .rd_pivot (d_piv),
      .rd_idx   (d_ridx),
      .out_valid(d_ov),
      .out_idx  (d_oidx),
      .out_len  (d_olen),
      .busy     (d_busy)
   );

   always_comb begin
      n_w = NW'(loaded_ff);
      if (n_w > NW'(pc_ff)) begin
         n_w = NW'(pc_ff);
      end
      if (n_w > NW'(MAX_POINTS)) begin
         n_w = NW'(MAX_POINTS);
      end
   end

   assign n_cnt    = LW'(n_w);
   assign last_idx = IW'(n_cnt - 1'b1);
   assign load_ok  = (NW'(loaded_ff) < NW'(pc_ff)) && (loaded_ff < LW'(MAX_POINTS));
   assign link_ok  = (req_end_a != '0) && (req_end_b != '0)
                     && (NW'(req_end_a) <= n_w) && (NW'(req_end_b) <= n_w);
   assign sum_w    = SW'(tot_ff) + SW'(best_key_ff);
   assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_POINT_COUNT);

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_total_length = rsp_data_ff;
   assign pready           = 1'b1;
   assign prdata = (paddr[2] == REG_POINT_COUNT) ?
                   {{(DATA_BITS-CFG_BITS){1'b0}}, pc_ff} : '0;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      loaded_in    = loaded_ff;
      pc_in        = pc_ff;
      fr_in        = fr_ff;
      save_par_in  = save_par_ff;
      ra_in        = ra_ff;
      endb_in      = endb_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      rb_in        = rb_ff;
      best_lab_in  = best_lab_ff;
      best_key_in  = best_key_ff;
      first_in     = first_ff;
      found_in     = found_ff;
      tot_in       = tot_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      tail_v_in    = d_ov;
      tail_idx_in  = d_oidx;
      tail_len_in  = d_olen;
      nd_re = 1'b0;
      nd_ra = '0;
      nd_we = 1'b0;
      nd_wa = '0;
      nd_wd = '0;
      pt_we = 1'b0;
      d_re  = 1'b0;
      d_piv = 1'b0;
      d_ridx = '0;

      if (cfg_wr) begin
         pc_in = pwdata[CFG_BITS-1:0];
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  KIND_LOAD: begin
                     if (load_ok) begin
                        pt_we     = 1'b1;
                        nd_we     = 1'b1;
                        nd_wa     = IW'(loaded_ff);
                        nd_wd     = {IW'(loaded_ff), {IW{1'b0}}, {RW{1'b0}}};
                        loaded_in = loaded_ff + 1'b1;
                     end
                  end
                  KIND_LINK: begin
                     if (link_ok) begin
                        fr_in    = IW'(req_end_a - 1'b1);
                        endb_in  = IW'(req_end_b - 1'b1);
                        first_in = 1'b1;
                        ret_in   = S_LNK_B;
                        state_in = S_FND_RD;
                     end
                  end
                  KIND_FINISH: begin
                     tot_in = '0;
                     i_in   = '0;
                     if (n_cnt == '0) begin
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_INI_GO;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FND_RD: begin
            nd_re    = 1'b1;
            nd_ra    = fr_ff;
            state_in = S_FND_WT;
         end
         S_FND_WT: begin
            first_in = 1'b0;
            if (first_ff) begin
               save_par_in = nd_q_par;
            end
            if (nd_q_par == fr_ff) begin
               state_in = ret_ff;
            end else begin
               fr_in = nd_q_par;
               nd_re = 1'b1;
               nd_ra = nd_q_par;
            end
         end
         S_LNK_B: begin
            ra_in    = fr_ff;
            fr_in    = endb_ff;
            first_in = 1'b1;
            ret_in   = S_LNK_C;
            state_in = S_FND_RD;
         end
         S_LNK_C: begin
            if (fr_ff != ra_ff) begin
               lo_in    = (fr_ff < ra_ff) ? fr_ff : ra_ff;
               hi_in    = (fr_ff < ra_ff) ? ra_ff : fr_ff;
               nd_re    = 1'b1;
               nd_ra    = (fr_ff < ra_ff) ? ra_ff : fr_ff;
               state_in = S_LNK_W;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_LNK_W: begin
            nd_we    = 1'b1;
            nd_wa    = hi_ff;
            nd_wd    = {lo_ff, nd_q_lab, nd_q_key};
            state_in = S_IDLE;
         end
         S_INI_GO: begin
            fr_in    = i_ff;
            first_in = 1'b1;
            ret_in   = S_INI_WR;
            state_in = S_FND_RD;
         end
         S_INI_WR: begin
            nd_we = 1'b1;
            nd_wa = i_ff;
            nd_wd = {save_par_ff, fr_ff, {RW{1'b1}}};
            if (i_ff == last_idx) begin
               j_in     = '0;
               state_in = S_RL0_RD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_INI_GO;
            end
         end
         S_RL0_RD: begin
            nd_re    = 1'b1;
            nd_ra    = j_ff;
            state_in = S_RL0_CK;
         end
         S_RL0_CK: begin
            if (nd_q_lab == '0) begin
               ret_in   = S_RL0_NX;
               state_in = S_RLX_PIV;
            end else begin
               state_in = S_RL0_NX;
            end
         end
         S_RL0_NX: begin
            if (j_ff == last_idx) begin
               state_in = S_SEL_RD;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_RL0_RD;
            end
         end
         S_RLX_PIV: begin
            d_re     = 1'b1;
            d_piv    = 1'b1;
            d_ridx   = j_ff;
            k_in     = '0;
            state_in = S_RLX_RUN;
         end
         S_RLX_RUN: begin
            d_re   = 1'b1;
            d_ridx = k_ff;
            if (k_ff == last_idx) begin
               state_in = S_RLX_DRN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_RLX_DRN: begin
            if (!d_busy && !tail_v_ff) begin
               state_in = ret_ff;
            end
         end
         S_SEL_RD: begin
            nd_re    = 1'b1;
            nd_ra    = '0;
            i_in     = '0;
            found_in = 1'b0;
            state_in = S_SEL_CK;
         end
         S_SEL_CK: begin
            if ((nd_q_lab != '0) && (!found_ff || (nd_q_key < best_key_ff))) begin
               found_in    = 1'b1;
               best_key_in = nd_q_key;
               best_lab_in = nd_q_lab;
            end
            if (i_ff == last_idx) begin
               state_in = S_SEL_DN;
            end else begin
               nd_re = 1'b1;
               nd_ra = i_ff + 1'b1;
               i_in  = i_ff + 1'b1;
            end
         end
         S_SEL_DN: begin
            if (!found_ff) begin
               state_in = S_EMIT;
            end else begin
               tot_in   = (sum_w > SW'(TOTAL_MAX)) ? TOTAL_MAX : sum_w[TOTAL_BITS-1:0];
               rb_in    = best_lab_ff;
               j_in     = '0;
               state_in = S_ABS_RD;
            end
         end
         S_ABS_RD: begin
            nd_re    = 1'b1;
            nd_ra    = j_ff;
            state_in = S_ABS_CK;
         end
         S_ABS_CK: begin
            if (nd_q_lab == rb_ff) begin
               nd_we    = 1'b1;
               nd_wa    = j_ff;
               nd_wd    = {nd_q_par, {IW{1'b0}}, nd_q_key};
               ret_in   = S_ABS_NX;
               state_in = S_RLX_PIV;
            end else begin
               state_in = S_ABS_NX;
            end
         end
         S_ABS_NX: begin
            if (j_ff == last_idx) begin
               state_in = S_PAR_RD;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_ABS_RD;
            end
         end
         S_PAR_RD: begin
            nd_re    = 1'b1;
            nd_ra    = rb_ff;
            state_in = S_PAR_WR;
         end
         S_PAR_WR: begin
            nd_we    = 1'b1;
            nd_wa    = rb_ff;
            nd_wd    = {{IW{1'b0}}, nd_q_lab, nd_q_key};
            state_in = S_SEL_RD;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = tot_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (d_ov) begin
         nd_re = 1'b1;
         nd_ra = d_oidx;
      end
      if (tail_v_ff) begin
         nd_we = 1'b1;
         nd_wa = tail_idx_ff;
         nd_wd = {nd_q_par, nd_q_lab, (tail_len_ff < nd_q_key) ? tail_len_ff : nd_q_key};
      end
   end

   always_ff @(posedge clock) begin
      ret_ff      <= ret_in;
      fr_ff       <= fr_in;
      save_par_ff <= save_par_in;
      ra_ff       <= ra_in;
      endb_ff     <= endb_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      rb_ff       <= rb_in;
      best_lab_ff <= best_lab_in;
      best_key_ff <= best_key_in;
      first_ff    <= first_in;
      found_ff    <= found_in;
      tot_ff      <= tot_in;
      rsp_data_ff <= rsp_data_in;
      tail_idx_ff <= tail_idx_in;
      tail_len_ff <= tail_len_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         loaded_ff    <= '0;
         pc_ff        <= POINT_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
         tail_v_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         tail_v_ff    <= tail_v_in;
      end
   end
endmodule
